FILE: sv/bbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbp_pkg;
   localparam int MAX_PATCH_DIM_DEF = 1024;
   localparam int FRAC_BITS_DEF = 16;
   localparam int SIZE_W = 11;
   localparam int POS_W = 10;
   localparam int PIX_W = 8;
   localparam int IDX_W = 4;
   localparam int GRID_N = 4;
   localparam int GRID_AW = 2;
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   typedef struct packed {
      logic               is_eval;
      logic [IDX_W-1:0]   idx;
      logic [PIX_W-1:0]   val;
      logic [SIZE_W-1:0]  pos_u;
      logic [SIZE_W-1:0]  last_u;
      logic [SIZE_W-1:0]  pos_v;
      logic [SIZE_W-1:0]  last_v;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SQ, S_CUBE, S_ROW, S_ACC, S_DONE
   } state_type;
endpackage
`default_nettype wire

FILE: sv/bbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: sv/bbp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bbp_front import bbp_pkg::*; #(
   parameter int MAX_PATCH_DIM = MAX_PATCH_DIM_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_func,
   input  wire logic [IDX_W-1:0]  req_point_index,
   input  wire logic [PIX_W-1:0]  req_point_value,
   input  wire logic [POS_W-1:0]  req_col,
   input  wire logic [POS_W-1:0]  req_row,
   input  wire logic [SIZE_W-1:0] req_patch_width,
   input  wire logic [SIZE_W-1:0] req_patch_height,
   output logic                   q_valid,
   output entry_type              q_entry,
   input  wire logic              q_pop
);
   entry_type      slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           push_ok;
   entry_type      cls;

   function automatic logic [SIZE_W-1:0] last_of(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] sz;
      sz = size;
      if (32'(size) > MAX_PATCH_DIM) begin
         sz = SIZE_W'(MAX_PATCH_DIM);
      end
      return (sz > SIZE_W'(1)) ? sz - SIZE_W'(1) : '0;
   endfunction

   function automatic logic [SIZE_W-1:0] pos_of(input logic [POS_W-1:0] pos,
                                                input logic [SIZE_W-1:0] last);
      logic [SIZE_W-1:0] p;
      p = SIZE_W'(pos);
      return (p > last) ? last : p;
   endfunction

   always_comb begin
      cls.is_eval = (req_func == FUNC_EVAL);
      cls.idx     = req_point_index;
      cls.val     = req_point_value;
      cls.last_u  = last_of(req_patch_height);
      cls.last_v  = last_of(req_patch_width);
      cls.pos_u   = pos_of(req_row, cls.last_u);
      cls.pos_v   = pos_of(req_col, cls.last_v);
   end

   assign req_full = (count_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign q_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + 2'(push_ok) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule
`default_nettype wire

FILE: sv/bbp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bbp_back import bbp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire entry_type        q_entry,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [PIX_W-1:0]      rsp_pixel_value,
   output logic                  rsp_is_pixel
);
   localparam int PW = FRAC_BITS + 1;
   localparam int RW = FRAC_BITS + 8;
   localparam int AW = 2 * FRAC_BITS + 10;
   localparam int CW = $clog2(FRAC_BITS + 1);
   localparam logic [PW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]   out_pix_ff, out_pix_in;
   logic               out_is_ff, out_is_in;
   logic               out_free;
   logic               ram_we;
   logic [GRID_AW-1:0] raddr;
   logic [PIX_W-1:0]   rd [GRID_N];

   logic [SIZE_W-1:0]  rem_ff [2];
   logic [SIZE_W-1:0]  rem_in [2];
   logic [SIZE_W-1:0]  last_ff [2];
   logic [PW-1:0]      quo_ff [2];
   logic [PW-1:0]      quo_in [2];
   logic [PW-1:0]      p_ff [2];
   logic [PW-1:0]      q_ff [2];
   logic [PW-1:0]      p2_ff [2];
   logic [PW-1:0]      q2_ff [2];
   logic [PW-1:0]      w_ff [2][GRID_N];
   logic [RW-1:0]      r_ff [GRID_N];
   logic [RW-1:0]      r_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [PIX_W-1:0]   pix;

   assign out_free        = !out_valid_ff || rsp_pop;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_value = out_pix_ff;
   assign rsp_is_pixel    = out_is_ff;

   for (genvar j = 0; j < GRID_N; j++) begin : g_col
      bbp_ram #(.WIDTH(PIX_W), .DEPTH(GRID_N)) u_ram (
         .clock (clock),
         .we    (ram_we && (q_entry.idx[GRID_AW-1:0] == GRID_AW'(j))),
         .waddr (q_entry.idx[IDX_W-1:GRID_AW]),
         .wdata (q_entry.val),
         .raddr (raddr),
         .rdata (rd[j])
      );
   end

   always_comb begin
      logic [SIZE_W:0] t;
      logic            ge;
      t = '0;
      for (int l = 0; l < 2; l++) begin
         if (state_ff == S_IDLE) begin
            ge        = (l == 0) ? (q_entry.pos_u >= q_entry.last_u)
                                 : (q_entry.pos_v >= q_entry.last_v);
            rem_in[l] = (l == 0) ? q_entry.pos_u - (ge ? q_entry.last_u : '0)
                                 : q_entry.pos_v - (ge ? q_entry.last_v : '0);
            quo_in[l] = PW'(ge);
         end else begin
            t         = {rem_ff[l], 1'b0};
            ge        = (t >= {1'b0, last_ff[l]});
            rem_in[l] = ge ? SIZE_W'(t - {1'b0, last_ff[l]}) : SIZE_W'(t);
            quo_in[l] = {quo_ff[l][PW-2:0], ge};
         end
      end
   end

   always_comb begin
      logic [RW+2:0] s;
      s = '0;
      for (int j = 0; j < GRID_N; j++) begin
         s = s + (RW+3)'(rd[j] * w_ff[1][j]);
      end
      r_in   = RW'(s);
      acc_in = acc_ff + AW'(w_ff[0][cnt_ff[GRID_AW-1:0]] * r_ff[cnt_ff[GRID_AW-1:0]]);
      pix    = (acc_ff[AW-1:2*FRAC_BITS] > 10'(255)) ? 8'hFF
                                                    : acc_ff[2*FRAC_BITS +: PIX_W];
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_pix_in   = out_pix_ff;
      out_is_in    = out_is_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      raddr        = '0;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (q_valid) begin
               if (!q_entry.is_eval) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     ram_we       = 1'b1;
                     out_valid_in = 1'b1;
                     out_pix_in   = '0;
                     out_is_in    = 1'b0;
                  end
               end else begin
                  q_pop    = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(FRAC_BITS - 1)) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            state_in = S_CUBE;
         end
         S_CUBE: begin
            cnt_in   = '0;
            state_in = S_ROW;
         end
         S_ROW: begin
            raddr  = cnt_ff[GRID_AW-1:0] + GRID_AW'(1);
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(GRID_N - 1)) begin
               cnt_in   = '0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(GRID_N - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pix_in   = pix;
               out_is_in    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      logic [2*PW-1:0] m0, m1, m2, m3;
      out_pix_ff <= out_pix_in;
      out_is_ff  <= out_is_in;
      if ((state_ff == S_IDLE && q_pop) || state_ff == S_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (state_ff == S_IDLE) begin
         last_ff[0] <= q_entry.last_u;
         last_ff[1] <= q_entry.last_v;
      end
      for (int l = 0; l < 2; l++) begin
         if (state_ff == S_SQ) begin
            p_ff[l]  <= (last_ff[l] == '0) ? '0 : quo_ff[l];
            q_ff[l]  <= ONE - ((last_ff[l] == '0) ? '0 : quo_ff[l]);
            m0       = quo_ff[l] * quo_ff[l];
            m1       = (ONE - quo_ff[l]) * (ONE - quo_ff[l]);
            p2_ff[l] <= (last_ff[l] == '0) ? '0 : m0[2*FRAC_BITS -: PW];
            q2_ff[l] <= (last_ff[l] == '0) ? ONE : m1[2*FRAC_BITS -: PW];
         end
         if (state_ff == S_CUBE) begin
            m0 = q2_ff[l] * q_ff[l];
            m1 = q2_ff[l] * p_ff[l];
            m2 = p2_ff[l] * q_ff[l];
            m3 = p2_ff[l] * p_ff[l];
            w_ff[l][0] <= m0[2*FRAC_BITS -: PW];
            w_ff[l][1] <= PW'((PW+2)'(m1[2*FRAC_BITS -: PW]) * (PW+2)'(3));
            w_ff[l][2] <= PW'((PW+2)'(m2[2*FRAC_BITS -: PW]) * (PW+2)'(3));
            w_ff[l][3] <= m3[2*FRAC_BITS -: PW];
         end
      end
      if (state_ff == S_ROW) begin
         r_ff[cnt_ff[GRID_AW-1:0]] <= r_in;
      end
      if (state_ff == S_CUBE) begin
         acc_ff <= '0;
      end else if (state_ff == S_ACC) begin
         acc_ff <= acc_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/bicubic_bezier_patch_eval.sv
// Push to empty low: an evaluate passes the queue, DIV, SQ, CUBE, ROW, ACC, DONE and the
// output register; a load, the queue and output register (one per cycle while popped).
// Evaluates go one at a time, paced by the bit-serial divider and row-by-row accumulate.
// A two-entry queue sits between front and back; results leave from an output register.
// Reset: synchronous, active high; clears queue and state, control points keep contents.
`timescale 1ns / 1ps
`default_nettype none
module bicubic_bezier_patch_eval import bbp_pkg::*; #(
   parameter int MAX_PATCH_DIM = MAX_PATCH_DIM_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_func,
   input  wire logic [IDX_W-1:0]  req_point_index,
   input  wire logic [PIX_W-1:0]  req_point_value,
   input  wire logic [POS_W-1:0]  req_col,
   input  wire logic [POS_W-1:0]  req_row,
   input  wire logic [SIZE_W-1:0] req_patch_width,
   input  wire logic [SIZE_W-1:0] req_patch_height,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [PIX_W-1:0]       rsp_pixel_value,
   output logic                   rsp_is_pixel
);
   logic      q_valid;
   logic      q_pop;
   entry_type q_entry;

   bbp_front #(.MAX_PATCH_DIM(MAX_PATCH_DIM)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_point_index  (req_point_index),
      .req_point_value  (req_point_value),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_patch_width  (req_patch_width),
      .req_patch_height (req_patch_height),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop)
   );

   bbp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_is_pixel    (rsp_is_pixel)
   );
endmodule
`default_nettype wire

FILE: sv/bbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bbp_checker import bbp_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_full,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire logic [PIX_W-1:0] rsp_pixel_value,
   input wire logic             rsp_is_pixel
);
   a_reset_clear: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not clear after reset");
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_is_pixel) |-> (rsp_pixel_value == '0))
      else $error("load acknowledge carries nonzero pixel");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pixel_value)
                                    && $stable(rsp_is_pixel)))
      else $error("waiting transaction changed");
endmodule

bind bicubic_bezier_patch_eval bbp_checker u_bbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_pixel_value (rsp_pixel_value),
   .rsp_is_pixel    (rsp_is_pixel)
);
`default_nettype wire

FILE: verif/bbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bbp_scoreboard import bbp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire logic              req_full,
   input  wire logic              req_func,
   input  wire logic [IDX_W-1:0]  req_point_index,
   input  wire logic [PIX_W-1:0]  req_point_value,
   input  wire logic [POS_W-1:0]  req_col,
   input  wire logic [POS_W-1:0]  req_row,
   input  wire logic [SIZE_W-1:0] req_patch_width,
   input  wire logic [SIZE_W-1:0] req_patch_height,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop,
   input  wire logic [PIX_W-1:0]  rsp_pixel_value,
   input  wire logic              rsp_is_pixel,
   output int                     fail_count,
   output int                     pending_count
);
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             is_pixel;
   } surface_result_type;

   localparam int FB = FRAC_BITS_DEF;

   logic [PIX_W-1:0]   grid_points [16];
   surface_result_type pending_results [$];

   assign pending_count = pending_results.size();

   function automatic logic [63:0] curve_param(logic [63:0] pos, logic [63:0] size);
      logic [63:0] last;
      if (size > 64'(MAX_PATCH_DIM_DEF)) size = 64'(MAX_PATCH_DIM_DEF);
      if (size <= 64'd1) return 64'd0;
      last = size - 64'd1;
      if (pos > last) pos = last;
      return (pos << FB) / last;
   endfunction

   function automatic void bernstein(input logic [63:0] p, output logic [63:0] w [4]);
      logic [63:0] q, p2, q2;
      q  = (64'd1 << FB) - p;
      p2 = (p * p) >> FB;
      q2 = (q * q) >> FB;
      w[0] = (q2 * q) >> FB;
      w[1] = 64'd3 * ((q2 * p) >> FB);
      w[2] = 64'd3 * ((p2 * q) >> FB);
      w[3] = (p2 * p) >> FB;
   endfunction

   function automatic logic [PIX_W-1:0] surface_value(logic [POS_W-1:0] col,
         logic [POS_W-1:0] row, logic [SIZE_W-1:0] pw, logic [SIZE_W-1:0] ph);
      logic [63:0] wu [4];
      logic [63:0] wv [4];
      logic [63:0] total, acc;
      total = 64'd0;
      bernstein(curve_param(64'(row), 64'(ph)), wu);
      bernstein(curve_param(64'(col), 64'(pw)), wv);
      for (int i = 0; i < 4; i++) begin
         acc = 64'd0;
         for (int j = 0; j < 4; j++) acc += 64'(grid_points[i*4+j]) * wv[j];
         total += wu[i] * acc;
      end
      total >>= 2 * FB;
      if (total > 64'd255) total = 64'd255;
      return total[PIX_W-1:0];
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      surface_result_type r, e;
      if (!reset && req_push && !req_full) begin
         if (req_func == FUNC_LOAD) begin
            grid_points[req_point_index] = req_point_value;
            r = '{pixel: '0, is_pixel: 1'b0};
         end else begin
            r = '{pixel: surface_value(req_col, req_row, req_patch_width,
                  req_patch_height), is_pixel: 1'b1};
         end
         pending_results.push_back(r);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            report("unexpected transaction", 1, 0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_is_pixel !== e.is_pixel)
               report("is_pixel", int'(rsp_is_pixel), int'(e.is_pixel));
            if (rsp_pixel_value !== e.pixel)
               report("pixel_value", int'(rsp_pixel_value), int'(e.pixel));
         end
      end
   end
endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb import bbp_pkg::*;;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_func = 1'b0;
   logic [IDX_W-1:0] req_point_index = '0;
   logic [PIX_W-1:0] req_point_value = '0;
   logic [POS_W-1:0] req_col = '0;
   logic [POS_W-1:0] req_row = '0;
   logic [SIZE_W-1:0] req_patch_width = 11'd1;
   logic [SIZE_W-1:0] req_patch_height = 11'd1;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [PIX_W-1:0] rsp_pixel_value;
   logic rsp_is_pixel;
   int fail_count, pending_count;
   bit hold_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bicubic_bezier_patch_eval dut (.*);
   bbp_scoreboard chk (.*);

   task automatic send(logic f, logic [IDX_W-1:0] idx, logic [PIX_W-1:0] val,
         logic [POS_W-1:0] c, logic [POS_W-1:0] r,
         logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
      req_push <= 1'b1;
      req_func <= f;
      req_point_index <= idx;
      req_point_value <= val;
      req_col <= c;
      req_row <= r;
      req_patch_width <= w;
      req_patch_height <= h;
      do @(posedge clock); while (req_full);
   endtask

   task automatic gap();
      int n;
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
      if (n != 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [SIZE_W-1:0] rand_size();
      case ($urandom_range(0, 9))
         0: return SIZE_W'($urandom_range(0, 2));
         1: return SIZE_W'($urandom_range(1000, 2047));
         2: return 11'd1024;
         default: return SIZE_W'($urandom_range(2, 64));
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_off) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 1) == 0);
   end

   initial begin
      #20_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      logic [SIZE_W-1:0] w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 16; i++)
         send(FUNC_LOAD, IDX_W'(i), PIX_W'(i[0] ? 255 : 0), 10'd0, 10'd0, 11'd1, 11'd1);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd0, 10'd0, 11'd0, 11'd0);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd1023, 10'd1023, 11'd2047, 11'd2047);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd1023, 10'd1023, 11'd1024, 11'd1024);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd1023, 10'd0, 11'd1, 11'd5);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd500, 10'd700, 11'd1000, 11'd999);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd5, 10'd9, 11'd11, 11'd10);
      for (int i = 0; i < 16; i++)
         send(FUNC_LOAD, IDX_W'(i), 8'hFF, 10'd0, 10'd0, 11'd1, 11'd1);
      send(FUNC_EVAL, 4'd0, 8'd0, 10'd3, 10'd3, 11'd7, 11'd7);
      hold_off = 1'b1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 12; i++)
            send(FUNC_EVAL, 4'd0, 8'd0, POS_W'(i), POS_W'(i), 11'd12, 11'd12);
      join
      for (int n = 0; n < 800; n++) begin
         if ($urandom_range(0, 3) == 0)
            send(FUNC_LOAD, IDX_W'($urandom), PIX_W'($urandom), POS_W'($urandom),
                 POS_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
         else begin
            w = rand_size();
            h = rand_size();
            send(FUNC_EVAL, IDX_W'($urandom), PIX_W'($urandom),
                 $urandom_range(0, 3) == 0 ? POS_W'($urandom) : POS_W'($urandom_range(0, w)),
                 $urandom_range(0, 3) == 0 ? POS_W'($urandom) : POS_W'($urandom_range(0, h)),
                 w, h);
         end
         gap();
      end
      req_push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

FILE: sim.f
sv/bbp_pkg.sv
sv/bbp_ram.sv
sv/bbp_front.sv
sv/bbp_back.sv
sv/bicubic_bezier_patch_eval.sv
sv/bbp_checker.sv
verif/bbp_checker.sv
verif/tb.sv
